FILE: hdl/edvd_pkg.sv
`timescale 1ns / 1ps
// Shared types, field widths and constant tables of the valley detector.
package edvd_pkg;

  // Field widths of one input beat and one result beat
  localparam int OP_W    = 2;
  localparam int ROW_W   = 8;
  localparam int COL_W   = 7;
  localparam int PIX_W   = 8;
  localparam int STR_W   = 8;
  localparam int SUM_W   = 19;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 8;

  // Operation codes on the input stream
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_DETECT = 2'd2;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_WRITE,
    CMD_DETECT,
    CMD_ZERO
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pixel;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WSUM,
    BK_TAPS,
    BK_FINISH
  } bk_state_e;

  // Window taps: index 0 is the centre, then four taps (a, b, d, e) per direction
  localparam int NTAPS  = 33;
  localparam int STEP_W = 6;
  localparam int NDIRS  = 8;
  localparam int DIR_W  = 3;

  localparam int TAP_DR [NTAPS] = '{
     0,
     0,  0,  0,  0,
    -2, -1,  1,  2,
    -4, -2,  2,  4,
    -4, -2,  2,  4,
    -4, -2,  2,  4,
    -4, -2,  2,  4,
    -4, -2,  2,  4,
    -2, -1,  1,  2
  };

  localparam int TAP_DC [NTAPS] = '{
     0,
    -4, -2,  2,  4,
    -4, -2,  2,  4,
    -4, -2,  2,  4,
    -2, -1,  1,  2,
     0,  0,  0,  0,
     2,  1, -1, -2,
     4,  2, -2, -4,
     4,  2, -2, -4
  };

  localparam int DIR_WEIGHT [NDIRS] = '{5, 4, 3, 2, 1, 2, 3, 4};

  // Reciprocals for exact division of small values by 7 and by 5
  localparam logic [13:0] RECIP7      = 14'd9363;
  localparam logic [13:0] RECIP5      = 14'd13108;
  localparam int          RECIP_SHIFT = 16;

endpackage

FILE: hdl/edvd_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module edvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/edvd_front.sv
`timescale 1ns / 1ps
// Front end: unpacks input beats, classifies them and pushes commands.
module edvd_front #(
  parameter int FRAME_ROWS = 160,
  parameter int FRAME_COLS = 90
) (
  input  logic                      s_tvalid_i,
  output logic                      s_tready_o,
  input  logic [edvd_pkg::S_DATA_W-1:0] s_tdata_i,
  input  logic                      full_i,
  output logic                      push_o,
  output edvd_pkg::cmd_t            cmd_o
);

  import edvd_pkg::*;

  logic [OP_W-1:0]  op;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [PIX_W-1:0] pixel;
  logic             in_frame;
  logic             keep;
  cmd_e             kind;

  // Unpack the beat
  assign op    = s_tdata_i[OP_W-1:0];
  assign row   = s_tdata_i[OP_W +: ROW_W];
  assign col   = s_tdata_i[OP_W+ROW_W +: COL_W];
  assign pixel = s_tdata_i[OP_W+ROW_W+COL_W +: PIX_W];

  assign in_frame = (int'(row) < FRAME_ROWS) && (int'(col) < FRAME_COLS);

  // Classify: drop unknown ops and off-frame writes, answer off-frame detects with zero
  always_comb begin
    keep = 1'b1;
    kind = CMD_CLEAR;
    unique case (op)
      OP_CLEAR: begin
        kind = CMD_CLEAR;
      end
      OP_WRITE: begin
        kind = CMD_WRITE;
        keep = in_frame;
      end
      OP_DETECT: begin
        kind = in_frame ? CMD_DETECT : CMD_ZERO;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign s_tready_o  = !full_i;
  assign push_o      = s_tvalid_i && !full_i && keep;
  assign cmd_o.kind  = kind;
  assign cmd_o.row   = row;
  assign cmd_o.col   = col;
  assign cmd_o.pixel = pixel;

endmodule

FILE: hdl/edvd_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front and the back.
module edvd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  edvd_pkg::cmd_t wdata_i,
  input  logic           pop_i,
  output edvd_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  import edvd_pkg::*;

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: hdl/edvd_back.sv
`timescale 1ns / 1ps
// Back end: frame and band-sum storage, window sequencer and response pipeline.
module edvd_back #(
  parameter int FRAME_ROWS = 160,
  parameter int FRAME_COLS = 90,
  parameter int BAND_ROWS  = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  edvd_pkg::cmd_t              head_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [edvd_pkg::STR_W-1:0]  m_tdata_o
);

  import edvd_pkg::*;

  localparam int FRAME_PIX = FRAME_ROWS * FRAME_COLS;
  localparam int AW        = (FRAME_PIX > 1) ? $clog2(FRAME_PIX) : 1;
  localparam int ROW_SPAN  = 1 << ROW_W;
  localparam int NBANDS    = (FRAME_ROWS + BAND_ROWS - 1) / BAND_ROWS;
  localparam int NB_REACH  = (ROW_SPAN + BAND_ROWS - 1) / BAND_ROWS;
  localparam int NB        = (NBANDS < NB_REACH) ? NBANDS : NB_REACH;
  localparam int BAND_W    = (NB > 1) ? $clog2(NB) : 1;
  localparam int BAND_PIX  = BAND_ROWS * FRAME_COLS;

  // Sequencer state
  bk_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [PIX_W-1:0] px_q;

  logic pop;
  logic out_free;
  logic pipe_empty;
  logic clr_bands;
  logic fram_we;
  logic bram_we;
  logic issue;
  logic load_out;
  logic [STR_W-1:0] out_val;

  // Address generation
  logic [ROW_W-1:0]  row_sel;
  logic [COL_W-1:0]  col_sel;
  logic signed [10:0] rr;
  logic signed [8:0]  cc;
  logic              tap_in_frame;
  logic [AW-1:0]     frm_addr;
  logic [PIX_W-1:0]  frm_rdata;

  // Band sums
  logic [BAND_W-1:0] band_lut [ROW_SPAN];
  logic [BAND_W-1:0] band_sel;
  logic [NB-1:0]     band_vld_q;
  logic              bvld_q;
  logic [SUM_W-1:0]  brdata;
  logic [SUM_W-1:0]  bsum;
  logic [31:0]       need;
  logic              gate_q;

  // Tap pipeline
  logic              s1_vld_q;
  logic              s1_zero_q;
  logic [STEP_W-1:0] s1_step_q;
  logic [STEP_W-1:0] s1_sm1;
  logic [PIX_W-1:0]  tap;
  logic signed [11:0] t12;
  logic signed [11:0] c12;
  logic signed [11:0] n_sum;
  logic [PIX_W-1:0]  centre_q;
  logic signed [11:0] acc_q;
  logic              a_gt_q;

  logic              s2_vld_q;
  logic              s2_ok_q;
  logic [10:0]       s2_n_q;
  logic [DIR_W-1:0]  s2_dir_q;

  logic              s3_vld_q;
  logic              s3_ok_q;
  logic [7:0]        s3_q_q;
  logic [DIR_W-1:0]  s3_dir_q;
  logic [24:0]       p7;

  logic              s4_vld_q;
  logic              s4_ok_q;
  logic [10:0]       s4_x_q;
  logic [24:0]       p5;
  logic [STR_W-1:0]  resp;
  logic [STR_W-1:0]  best_q;

  logic              o_vld_q;
  logic [STR_W-1:0]  o_data_q;

  assign out_free   = !o_vld_q || m_tready_i;
  assign pipe_empty = !s1_vld_q && !s2_vld_q && !s3_vld_q && !s4_vld_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (pop) begin
          unique case (head_i.kind)
            CMD_WRITE:  state_d = BK_WSUM;
            CMD_DETECT: state_d = BK_TAPS;
            CMD_CLEAR:  state_d = BK_IDLE;
            CMD_ZERO:   state_d = BK_IDLE;
          endcase
        end
      end
      BK_WSUM: begin
        state_d = BK_IDLE;
      end
      BK_TAPS: begin
        if (step_q == STEP_W'(NTAPS - 1)) begin
          state_d = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (pipe_empty && out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop       = 1'b0;
    clr_bands = 1'b0;
    fram_we   = 1'b0;
    bram_we   = 1'b0;
    issue     = 1'b0;
    load_out  = 1'b0;
    out_val   = '0;
    unique case (state_q)
      BK_IDLE: begin
        pop       = !empty_i && ((head_i.kind != CMD_ZERO) || out_free);
        clr_bands = pop && (head_i.kind == CMD_CLEAR);
        fram_we   = pop && (head_i.kind == CMD_WRITE);
        load_out  = pop && (head_i.kind == CMD_ZERO);
      end
      BK_WSUM: begin
        bram_we = 1'b1;
      end
      BK_TAPS: begin
        issue = 1'b1;
      end
      BK_FINISH: begin
        load_out = pipe_empty && out_free;
        out_val  = gate_q ? best_q : '0;
      end
      default: ;
    endcase
  end

  assign pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_TAPS) begin
        step_q <= (step_q == STEP_W'(NTAPS - 1)) ? '0 : step_q + 1'b1;
      end
    end
  end

  // Latch the popped command
  always_ff @(posedge clk_i) begin
    if (pop) begin
      row_q <= head_i.row;
      col_q <= head_i.col;
      px_q  <= head_i.pixel;
    end
  end

  // Tap coordinates; step is zero outside the tap sweep, giving the command's own pixel
  assign row_sel = (state_q == BK_IDLE) ? head_i.row : row_q;
  assign col_sel = (state_q == BK_IDLE) ? head_i.col : col_q;
  assign rr = signed'({3'b000, row_sel}) + 11'(TAP_DR[step_q]);
  assign cc = signed'({2'b00, col_sel}) + 9'(TAP_DC[step_q]);
  assign tap_in_frame = (rr >= 0) && (int'(rr) < FRAME_ROWS)
                     && (cc >= 0) && (int'(cc) < FRAME_COLS);
  assign frm_addr = AW'(int'(rr[9:0]) * FRAME_COLS + int'(cc[7:0]));

  edvd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FRAME_PIX)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fram_we),
    .waddr_i (frm_addr),
    .wdata_i (head_i.pixel),
    .re_i    (issue),
    .raddr_i (frm_addr),
    .rdata_o (frm_rdata)
  );

  // Row to band lookup, built at elaboration
  for (genvar g = 0; g < ROW_SPAN; g++) begin : g_band_lut
    localparam int BI = (g < FRAME_ROWS) ? (g / BAND_ROWS) : 0;
    assign band_lut[g] = BAND_W'(BI);
  end

  assign band_sel = band_lut[row_sel];

  edvd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (NB)
  ) u_band_ram (
    .clk_i   (clk_i),
    .we_i    (bram_we),
    .waddr_i (band_sel),
    .wdata_i (bsum + SUM_W'(px_q)),
    .re_i    (1'b1),
    .raddr_i (band_sel),
    .rdata_o (brdata)
  );

  // A band not written since the last clear reads as zero
  assign bsum = bvld_q ? brdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_vld_q <= '0;
      bvld_q     <= 1'b0;
    end else begin
      bvld_q <= band_vld_q[band_sel];
      if (clr_bands) begin
        band_vld_q <= '0;
      end else if (bram_we) begin
        band_vld_q[band_sel] <= 1'b1;
      end
    end
  end

  // Centre must lie below floor(sum / band pixels): (centre + 1) * band pixels <= sum
  assign need = 32'({1'b0, centre_q} + 9'd1) * 32'(BAND_PIX);

  always_ff @(posedge clk_i) begin
    gate_q <= (need <= 32'(bsum));
  end

  // Stage 1: returned tap, accumulate one direction over four taps
  assign tap    = s1_zero_q ? '0 : frm_rdata;
  assign s1_sm1 = s1_step_q - 1'b1;
  assign t12    = signed'({4'b0000, tap});
  assign c12    = signed'({4'b0000, centre_q});
  assign n_sum  = acc_q + 12'(t12 * 3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q && (s1_step_q != '0) && (s1_sm1[1:0] == 2'd3);
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_zero_q <= !tap_in_frame;
    s1_step_q <= step_q;
    if (s1_vld_q) begin
      if (s1_step_q == '0) begin
        centre_q <= tap;
      end else begin
        case (s1_sm1[1:0])
          2'd0: begin
            acc_q  <= 12'(t12 * 3 - c12 * 4);
            a_gt_q <= (tap > centre_q);
          end
          2'd3: begin
            s2_n_q   <= n_sum[10:0];
            s2_ok_q  <= a_gt_q && (tap > centre_q) && (n_sum > 12'sd6);
            s2_dir_q <= s1_sm1[DIR_W+1:2];
          end
          default: begin
            acc_q <= acc_q - t12;
          end
        endcase
      end
    end
  end

  // Stage 2: divide by seven
  assign p7 = 25'(s2_n_q) * 25'(RECIP7);

  always_ff @(posedge clk_i) begin
    s3_q_q   <= p7[RECIP_SHIFT +: 8];
    s3_ok_q  <= s2_ok_q;
    s3_dir_q <= s2_dir_q;
  end

  // Stage 3: apply direction weight
  always_ff @(posedge clk_i) begin
    s4_x_q  <= 11'(s3_q_q) * 11'(DIR_WEIGHT[s3_dir_q]);
    s4_ok_q <= s3_ok_q;
  end

  // Stage 4: divide by five and keep the best qualifying response
  assign p5   = 25'(s4_x_q) * 25'(RECIP5);
  assign resp = p5[RECIP_SHIFT +: STR_W];

  always_ff @(posedge clk_i) begin
    if (pop) begin
      best_q <= '0;
    end else if (s4_vld_q && s4_ok_q && (resp > best_q)) begin
      best_q <= resp;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (load_out) begin
      o_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      o_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_data_q <= out_val;
    end
  end

  assign m_tvalid_o = o_vld_q;
  assign m_tdata_o  = o_data_q;

endmodule

FILE: hdl/eight_direction_valley_detector.sv
`timescale 1ns / 1ps
// Top level of the eight-direction valley detector.
//
//  Channel   Dir  Payload (tdata, lowest bit first)            Beat taken when
//  s_axis    in   op[1:0] row[9:2] col[16:10] pixel[24:17]     tvalid & tready
//  m_axis    out  line_strength[7:0]                           tvalid & tready
//
// A detect beat holds the back end for the command pop, 33 frame reads on the
// single frame-memory read port, one per cycle, and the response pipeline drain,
// and then until the output register is free. A pixel write also updates its
// band sum (read-modify-write); a clear takes only the pop. Reset clears the band
// sums at once; the frame memory holds no value until written. A two-entry command
// queue keeps input beats flowing while the back end works or the result waits.
module eight_direction_valley_detector #(
  parameter int FRAME_ROWS = 160,
  parameter int FRAME_COLS = 90,
  parameter int BAND_ROWS  = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // op[1:0], row[9:2], col[16:10], pixel[24:17], zero[31:25]
  input  logic [edvd_pkg::S_DATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // line_strength[7:0]
  output logic [edvd_pkg::M_DATA_W-1:0] m_axis_tdata
);

  import edvd_pkg::*;

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  edvd_front #(
    .FRAME_ROWS (FRAME_ROWS),
    .FRAME_COLS (FRAME_COLS)
  ) u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  edvd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  edvd_back #(
    .FRAME_ROWS (FRAME_ROWS),
    .FRAME_COLS (FRAME_COLS),
    .BAND_ROWS  (BAND_ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule
